// ===== hw/rtl/vvp_pkg.sv =====
// Shared constants, codes and types of the vertex view/projection transform.
package vvp_pkg;

    localparam int COORD_BITS        = 32;
    localparam int FRACTION_BITS     = 16;
    localparam int SCREEN_COORD_BITS = 16;

    localparam int COEF_COUNT   = 32;
    localparam int COEF_SEL_W   = $clog2(COEF_COUNT);
    localparam int PROJ_BASE    = 16;
    localparam int DIM_BITS     = 15;
    localparam int EPS_BITS     = 17;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 2;

    localparam int INQ_DEPTH    = 4;
    localparam int OUTQ_DEPTH   = 32;
    localparam int CREDIT_W     = $clog2(OUTQ_DEPTH) + 1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);
    localparam logic [EPS_BITS-1:0] EPS_RESET    = EPS_BITS'(1);

    typedef enum logic {
        OP_COEF_WRITE = 1'b0,
        OP_VERTEX     = 1'b1
    } vvp_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_W_EPSILON     = 2'd2
    } vvp_reg_t;

    typedef struct packed {
        logic                         operation;
        logic [COEF_SEL_W-1:0]        coef_select;
        logic signed [COORD_BITS-1:0] coef_value;
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic                         polygon_end;
    } vvp_item_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [EPS_BITS-1:0] eps;
    } vvp_cfg_t;

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pw;
        logic                         polygon_end;
    } vvp_clip_t;

    typedef struct packed {
        logic signed [SCREEN_COORD_BITS-1:0] screen_x;
        logic signed [SCREEN_COORD_BITS-1:0] screen_y;
        logic                                polygon_end_out;
        logic                                w_was_clamped;
        logic                                coord_saturated;
    } vvp_result_t;

endpackage

// ===== hw/rtl/vvp_in_if.sv =====
// Input channel carrying coefficient writes and vertices.
interface vvp_in_if
    import vvp_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [COEF_SEL_W-1:0]        coef_select;
    logic signed [COORD_BITS-1:0] coef_value;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         polygon_end;

    modport source (output valid, operation, coef_select, coef_value, vertex_x, vertex_y,
                    vertex_z, polygon_end, input ready);
    modport sink (input valid, operation, coef_select, coef_value, vertex_x, vertex_y,
                  vertex_z, polygon_end, output ready);
endinterface

// ===== hw/rtl/vvp_out_if.sv =====
// Output channel carrying screen-space results.
interface vvp_out_if
    import vvp_pkg::*;
();
    logic                                valid;
    logic                                ready;
    logic signed [SCREEN_COORD_BITS-1:0] screen_x;
    logic signed [SCREEN_COORD_BITS-1:0] screen_y;
    logic                                polygon_end_out;
    logic                                w_was_clamped;
    logic                                coord_saturated;

    modport source (output valid, screen_x, screen_y, polygon_end_out, w_was_clamped,
                    coord_saturated, input ready);
    modport sink (input valid, screen_x, screen_y, polygon_end_out, w_was_clamped,
                  coord_saturated, output ready);
endinterface

// ===== hw/rtl/vvp_front.sv =====
// Input queue that accepts beats and presents the oldest one for issue.
module vvp_front
    import vvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vvp_in_if.sink    in_ch,
    output vvp_item_t head,
    output logic      head_valid,
    input  logic      pop
);
    localparam int PTR_W = $clog2(INQ_DEPTH);

    vvp_item_t            mem [INQ_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic [PTR_W:0]       count_next;
    logic                 push;
    logic                 do_pop;

    assign in_ch.ready = (count_reg != (PTR_W + 1)'(INQ_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign head_valid  = (count_reg != '0);
    assign do_pop      = pop && head_valid;
    assign head        = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{operation:   in_ch.operation,
                                 coef_select: in_ch.coef_select,
                                 coef_value:  in_ch.coef_value,
                                 vertex_x:    in_ch.vertex_x,
                                 vertex_y:    in_ch.vertex_y,
                                 vertex_z:    in_ch.vertex_z,
                                 polygon_end: in_ch.polygon_end};
        end
    end

endmodule

// ===== hw/rtl/vvp_matrix.sv =====
// Coefficient store and the pipelined view and projection matrix products.
module vvp_matrix
    import vvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      coef_we,
    input  logic      vertex_issue,
    input  vvp_item_t item,
    output logic      busy,
    output vvp_clip_t clip
);
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int ACC_W  = PROD_W + 2;

    function automatic logic signed [COORD_BITS-1:0] sat_acc(
        input logic signed [ACC_W-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (!v[ACC_W-1] && (|v[ACC_W-2:COORD_BITS-1]))
        begin
            r = {1'b0, {(COORD_BITS - 1){1'b1}}};
        end
        else if (v[ACC_W-1] && !(&v[ACC_W-2:COORD_BITS-1]))
        begin
            r = {1'b1, {(COORD_BITS - 1){1'b0}}};
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_BITS-1:0] coef_reg [COEF_COUNT];
    logic signed [COORD_BITS-1:0] vin [3];

    logic                         va_reg, vb_reg, vc_reg, vd_reg;
    logic                         pe_a_reg, pe_b_reg, pe_c_reg, pe_d_reg;
    logic signed [PROD_W-1:0]     prod_a_reg [4][3];
    logic signed [COORD_BITS-1:0] bias_a_reg [4];
    logic signed [ACC_W-1:0]      acc_b [4];
    logic signed [COORD_BITS-1:0] t_b_reg [4];
    logic signed [PROD_W-1:0]     prod_c_reg [4][4];
    logic signed [ACC_W-1:0]      acc_d [4];
    logic signed [COORD_BITS-1:0] p_d_reg [4];

    assign vin[0] = item.vertex_x;
    assign vin[1] = item.vertex_y;
    assign vin[2] = item.vertex_z;
    assign busy   = va_reg;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_reg[item.coef_select] <= item.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= vertex_issue;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc_b[r] = ACC_W'(prod_a_reg[r][0] >>> FRACTION_BITS)
                     + ACC_W'(prod_a_reg[r][1] >>> FRACTION_BITS)
                     + ACC_W'(prod_a_reg[r][2] >>> FRACTION_BITS)
                     + ACC_W'(bias_a_reg[r]);
            acc_d[r] = ACC_W'(prod_c_reg[r][0] >>> FRACTION_BITS)
                     + ACC_W'(prod_c_reg[r][1] >>> FRACTION_BITS)
                     + ACC_W'(prod_c_reg[r][2] >>> FRACTION_BITS)
                     + ACC_W'(prod_c_reg[r][3] >>> FRACTION_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        pe_a_reg <= item.polygon_end;
        pe_b_reg <= pe_a_reg;
        pe_c_reg <= pe_b_reg;
        pe_d_reg <= pe_c_reg;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_a_reg[r][c] <= PROD_W'(coef_reg[c * 4 + r]) * PROD_W'(vin[c]);
            end
            // The implicit w of one contributes the fourth column unchanged.
            bias_a_reg[r] <= coef_reg[12 + r];
            t_b_reg[r]    <= sat_acc(acc_b[r]);
            for (int c = 0; c < 4; c++)
            begin
                prod_c_reg[r][c] <= PROD_W'(coef_reg[PROJ_BASE + c * 4 + r])
                                  * PROD_W'(t_b_reg[c]);
            end
            p_d_reg[r] <= sat_acc(acc_d[r]);
        end
    end

    assign clip = '{valid: vd_reg, px: p_d_reg[0], py: p_d_reg[1], pw: p_d_reg[3],
                    polygon_end: pe_d_reg};

endmodule

// ===== hw/rtl/vvp_screen.sv =====
// W clamp, viewport scaling and pipelined restoring division to screen pixels.
module vvp_screen
    import vvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vvp_cfg_t    cfg,
    input  vvp_clip_t   clip,
    output logic        res_valid,
    output vvp_result_t res
);
    localparam int QB    = SCREEN_COORD_BITS + 1;
    localparam int SUM_W = COORD_BITS + 2;
    localparam int NUM_W = SUM_W + DIM_BITS + 1;
    localparam int CMP_W = SUM_W + QB;
    localparam int ABS_W = COORD_BITS + 1;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QB-1:0]    q;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t            lx;
        lane_t            ly;
        logic [SUM_W-1:0] dmag;
        logic             pe;
        logic             clamp;
    } div_t;

    typedef struct packed {
        logic signed [SCREEN_COORD_BITS-1:0] value;
        logic                                hit;
    } sat_t;

    function automatic lane_t lane_step(input lane_t l, input logic [SUM_W-1:0] d,
                                        input int bitpos);
        lane_t            o;
        logic [CMP_W-1:0] trial;
        o     = l;
        trial = CMP_W'(d) << bitpos;
        if (CMP_W'(l.rem) >= trial)
        begin
            o.rem        = l.rem - trial[NUM_W-1:0];
            o.q[bitpos]  = 1'b1;
        end
        return o;
    endfunction

    function automatic sat_t lane_finish(input lane_t l);
        sat_t              s;
        logic signed [QB:0] v;
        v = l.neg ? -$signed({1'b0, l.q}) : $signed({1'b0, l.q});
        s.hit = 1'b1;
        if (l.ovf)
        begin
            s.value = l.neg ? {1'b1, {(SCREEN_COORD_BITS - 1){1'b0}}}
                            : {1'b0, {(SCREEN_COORD_BITS - 1){1'b1}}};
        end
        else if (!v[QB] && (|v[QB-1:SCREEN_COORD_BITS-1]))
        begin
            s.value = {1'b0, {(SCREEN_COORD_BITS - 1){1'b1}}};
        end
        else if (v[QB] && !(&v[QB-1:SCREEN_COORD_BITS-1]))
        begin
            s.value = {1'b1, {(SCREEN_COORD_BITS - 1){1'b0}}};
        end
        else
        begin
            s.value = v[SCREEN_COORD_BITS-1:0];
            s.hit   = 1'b0;
        end
        return s;
    endfunction

    function automatic lane_t lane_start(input logic signed [NUM_W-1:0] n, input logic dneg,
                                         input logic [SUM_W-1:0] d);
        lane_t l;
        l.rem = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
        l.q   = '0;
        l.neg = n[NUM_W-1] ^ dneg;
        l.ovf = (CMP_W'(l.rem) >= (CMP_W'(d) << QB));
        return l;
    endfunction

    // Clamp stage.
    logic [EPS_BITS-1:0]      eps;
    logic [ABS_W-1:0]         absw;
    logic                     clamp;
    logic signed [SUM_W-1:0]  wf;
    logic                     ve_reg, vf_reg, vg_reg;
    logic signed [SUM_W-1:0]  nx_e_reg, ny_e_reg, w_e_reg;
    logic                     clamp_e_reg, pe_e_reg;
    logic signed [NUM_W-1:0]  mx_f_reg, my_f_reg;
    logic signed [SUM_W-1:0]  d_f_reg;
    logic                     clamp_f_reg, pe_f_reg;
    logic [SUM_W-1:0]         dmag_f;
    div_t                     div_reg [QB + 1];
    logic                     dv_reg [QB + 1];
    sat_t                     sx, sy;
    vvp_result_t              res_reg;

    assign eps   = (cfg.eps == '0) ? EPS_BITS'(1) : cfg.eps;
    assign absw  = clip.pw[COORD_BITS-1] ? ABS_W'(-ABS_W'(clip.pw)) : ABS_W'(clip.pw);
    assign clamp = (absw < ABS_W'(eps));
    assign wf    = clamp ? $signed(SUM_W'(eps)) : SUM_W'(clip.pw);
    assign dmag_f = d_f_reg[SUM_W-1] ? SUM_W'(-d_f_reg) : SUM_W'(d_f_reg);
    assign sx    = lane_finish(div_reg[QB].lx);
    assign sy    = lane_finish(div_reg[QB].ly);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= clip.valid;
            vf_reg <= ve_reg;
            vg_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        nx_e_reg    <= SUM_W'(clip.px) + wf;
        ny_e_reg    <= wf - SUM_W'(clip.py);
        w_e_reg     <= wf;
        clamp_e_reg <= clamp;
        pe_e_reg    <= clip.polygon_end;

        mx_f_reg    <= NUM_W'(nx_e_reg) * NUM_W'($signed({1'b0, cfg.width}));
        my_f_reg    <= NUM_W'(ny_e_reg) * NUM_W'($signed({1'b0, cfg.height}));
        d_f_reg     <= w_e_reg <<< 1;
        clamp_f_reg <= clamp_e_reg;
        pe_f_reg    <= pe_e_reg;

        div_reg[0].lx    <= lane_start(mx_f_reg, d_f_reg[SUM_W-1], dmag_f);
        div_reg[0].ly    <= lane_start(my_f_reg, d_f_reg[SUM_W-1], dmag_f);
        div_reg[0].dmag  <= dmag_f;
        div_reg[0].pe    <= pe_f_reg;
        div_reg[0].clamp <= clamp_f_reg;

        res_reg <= '{screen_x: sx.value, screen_y: sy.value,
                     polygon_end_out: div_reg[QB].pe,
                     w_was_clamped: div_reg[QB].clamp,
                     coord_saturated: sx.hit || sy.hit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= vf_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k + 1] <= 1'b0;
            end
            else
            begin
                dv_reg[k + 1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k + 1].lx    <= lane_step(div_reg[k].lx, div_reg[k].dmag, QB - 1 - k);
            div_reg[k + 1].ly    <= lane_step(div_reg[k].ly, div_reg[k].dmag, QB - 1 - k);
            div_reg[k + 1].dmag  <= div_reg[k].dmag;
            div_reg[k + 1].pe    <= div_reg[k].pe;
            div_reg[k + 1].clamp <= div_reg[k].clamp;
        end
    end

    assign res_valid = vg_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/vvp_outq.sv =====
// Result queue that holds finished results until the receiver takes them.
module vvp_outq
    import vvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  vvp_result_t data,
    output logic        full,
    vvp_out_if.source   out_ch
);
    localparam int PTR_W = $clog2(OUTQ_DEPTH);

    vvp_result_t      mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             pop;
    vvp_result_t      head;

    assign full   = (count_reg == (PTR_W + 1)'(OUTQ_DEPTH));
    assign pop    = out_ch.valid && out_ch.ready;
    assign head   = mem[rd_ptr_reg];

    assign out_ch.valid           = (count_reg != '0);
    assign out_ch.screen_x        = head.screen_x;
    assign out_ch.screen_y        = head.screen_y;
    assign out_ch.polygon_end_out = head.polygon_end_out;
    assign out_ch.w_was_clamped   = head.w_was_clamped;
    assign out_ch.coord_saturated = head.coord_saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= data;
        end
    end

endmodule

// ===== hw/rtl/vertex_view_projection_transform.sv =====
// Top level of the vertex view/projection transform with viewport mapping.
// The in_ch channel carries two kinds of beat: a coefficient write, which fills
// one entry of the view or projection matrix and gives no result, and a vertex,
// which gives exactly one beat on out_ch with its screen position and flags.
// Both channels use valid and ready; a beat moves when both are high.
// The three configuration registers are written through cfg_write_en, cfg_index
// and cfg_data; the block leaves it to the user to write them only while it is idle.
// One vertex is taken every cycle while a result slot is free; the matrix
// products, clamp, scaling and a one-bit-per-stage divider are all pipelined.
// A coefficient write waits while the matrix is busy with the vertex just issued,
// so a write cannot issue in the cycle right after a vertex.
// Every issued vertex holds a slot in a 32-entry result queue, so when the
// receiver stalls, the block keeps accepting until those slots are spoken for.
// Reset clears the queues and loads width 640, height 480 and epsilon 1;
// matrix coefficients must be written before a vertex uses them.
module vertex_view_projection_transform
    import vvp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    vvp_in_if.sink                 in_ch,
    vvp_out_if.source              out_ch
);
    vvp_cfg_t             cfg_reg;
    vvp_item_t            head;
    logic                 head_valid;
    logic                 head_is_vertex;
    logic                 pop;
    logic                 vertex_issue;
    logic                 coef_we;
    logic                 matrix_busy;
    vvp_clip_t            clip;
    logic                 res_valid;
    vvp_result_t          res;
    logic                 outq_full;
    logic                 out_pop;
    logic [CREDIT_W-1:0]  credits_reg;
    logic [CREDIT_W-1:0]  credits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{width: WIDTH_RESET, height: HEIGHT_RESET, eps: EPS_RESET};
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.width  <= cfg_data[DIM_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.height <= cfg_data[DIM_BITS-1:0];
                REG_W_EPSILON:     cfg_reg.eps    <= cfg_data[EPS_BITS-1:0];
                default:           cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign head_is_vertex = (vvp_op_t'(head.operation) == OP_VERTEX);
    assign pop = head_valid && (head_is_vertex ? (credits_reg < CREDIT_W'(OUTQ_DEPTH))
                                               : !matrix_busy);
    assign vertex_issue = pop && head_is_vertex;
    assign coef_we      = pop && !head_is_vertex;
    assign out_pop      = out_ch.valid && out_ch.ready;

    always_comb
    begin
        credits_next = credits_reg;
        if (vertex_issue && !out_pop)
        begin
            credits_next = credits_reg + 1'b1;
        end
        else if (!vertex_issue && out_pop)
        begin
            credits_next = credits_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credits_reg <= '0;
        end
        else
        begin
            credits_reg <= credits_next;
        end
    end

    vvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    vvp_matrix u_matrix (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_we      (coef_we),
        .vertex_issue (vertex_issue),
        .item         (head),
        .busy         (matrix_busy),
        .clip         (clip)
    );

    vvp_screen u_screen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clip      (clip),
        .res_valid (res_valid),
        .res       (res)
    );

    vvp_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_valid),
        .data   (res),
        .full   (outq_full),
        .out_ch (out_ch)
    );

`ifndef ASSERT_OFF
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credits_reg <= CREDIT_W'(OUTQ_DEPTH))
        else $error("Reserved result slots exceed the queue depth.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !outq_full)
        else $error("A result arrived while the result queue was full.");

    a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (credits_reg != '0))
        else $error("A result is offered without a reserved slot.");

    a_write_after_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_issue |=> !coef_we)
        else $error("A coefficient write overtook a vertex in the matrix stages.");
`endif

endmodule
